FILE: rtl/deq_pkg.sv
`default_nettype none

package deq_pkg;

   // Command codes carried in the request word
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
   localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [2:0] CMD_POP_BACK   = 3'd2;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [2:0] CMD_CLEAR      = 3'd4;
   localparam logic [2:0] CMD_PEEK       = 3'd5;

   // Status codes returned in the response word
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_POP_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_PUSH_FULL = 2'd2;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
      logic               ends_valid;
      logic [6:0]         element_count;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SEND
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic exec;   // apply the accepted request to head, count and store
      logic load;   // capture both end slots from the store
   } ctrl_cmd_type;

endpackage

`default_nettype wire

FILE: rtl/double_ended_queue.sv
// Bounded double-ended queue of signed words held in a ring store.
//
// Request channel (req_valid / req_stall / req_data): each word carries a
// command (push back, push front, pop back, pop front, clear, peek; unused
// codes act as peek) and a value used by the pushes.
// Response channel (rsp_valid / rsp_stall / rsp_data): exactly one word per
// request, with the front and back values, an ends-valid flag, the element
// count and a status (done, pop on empty ignored, push on full ignored).
//
// An accepted command updates head, count and the written slot; the read
// state then reads both end slots from the store, which has a registered
// read, and the send state offers the response. The next request is taken
// in the same cycle that the pending response is taken.
// Reset empties the queue (head and count to zero); slot contents are not
// cleared and no clearing pass is needed. While the receiver stalls, the
// response holds and no new request is taken.

`default_nettype none

module double_ended_queue #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire deq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output deq_pkg::rsp_type      rsp_data
);

   deq_pkg::ctrl_cmd_type cmd;

   // sequence accept, read and send
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // hold head, count, status and the ring store
   deq_dp #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   // every accepted word is followed by a response once the read state has passed
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> ##1 rsp_valid)
      else $error("response missing after accepted request");

endmodule

`default_nettype wire

FILE: rtl/deq_ram.sv
`default_nettype none

module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

FILE: rtl/deq_ctrl.sv
`default_nettype none

module deq_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output deq_pkg::ctrl_cmd_type cmd
);

   deq_pkg::state_type state_ff;
   deq_pkg::state_type state_in;
   logic               accept;

   // Take a new word when idle, or when the pending result leaves this cycle
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cmd.load  = 1'b0;
      case (state_ff)
         deq_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         deq_pkg::ST_READ: begin
            cmd.load = 1'b1;
         end
         deq_pkg::ST_SEND: begin
            rsp_valid = 1'b1;
            req_stall = rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
      cmd.exec = req_valid && !req_stall;
   end

   assign accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         deq_pkg::ST_IDLE: begin
            if (accept) state_in = deq_pkg::ST_READ;
         end
         deq_pkg::ST_READ: begin
            state_in = deq_pkg::ST_SEND;
         end
         deq_pkg::ST_SEND: begin
            if (!rsp_stall) state_in = accept ? deq_pkg::ST_READ : deq_pkg::ST_IDLE;
         end
         default: begin
            state_in = deq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= deq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a stalled result must stay in the send state
   a_send_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (state_ff == deq_pkg::ST_SEND))
      else $error("result dropped while stalled");

endmodule

`default_nettype wire

FILE: rtl/deq_dp.sv
`default_nettype none

module deq_dp #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire deq_pkg::ctrl_cmd_type cmd,
   input  wire deq_pkg::req_type     req_data,
   output deq_pkg::rsp_type          rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic [AW-1:0] head_ff,   head_in;
   logic [CW-1:0] count_ff,  count_in;
   logic [1:0]    status_ff, status_in;

   logic          full, empty;
   logic [AW-1:0] head_inc, head_dec;
   logic [AW:0]   tail_sum, back_sum;
   logic [AW-1:0] tail_addr, back_addr;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [63:0]           value_wide;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [DATA_WIDTH-1:0] front_q, back_q;
   logic signed [DATA_WIDTH-1:0] front_s, back_s;
   logic [63:0]           front_ext, back_ext;

   assign full  = (count_ff == CW'(CAPACITY));
   assign empty = (count_ff == '0);

   assign head_inc = (head_ff == AW'(CAPACITY - 1)) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? AW'(CAPACITY - 1) : head_ff - 1'b1;

   // slot just past the back, used by push back
   assign tail_sum  = {1'b0, head_ff} + (AW+1)'(count_ff);
   assign tail_addr = (tail_sum >= (AW+1)'(CAPACITY)) ?
                      AW'(tail_sum - (AW+1)'(CAPACITY)) : AW'(tail_sum);

   // slot of the back element; junk when empty, then masked at the output
   assign back_sum  = tail_sum - 1'b1;
   assign back_addr = (back_sum >= (AW+1)'(CAPACITY)) ?
                      AW'(back_sum - (AW+1)'(CAPACITY)) : AW'(back_sum);

   assign value_wide = 64'($unsigned(req_data.value));
   assign wr_data    = value_wide[DATA_WIDTH-1:0];

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = tail_addr;
      if (cmd.exec) begin
         status_in = deq_pkg::STATUS_DONE;
         case (req_data.command)
            deq_pkg::CMD_PUSH_BACK: begin
               if (full) begin
                  status_in = deq_pkg::STATUS_PUSH_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            deq_pkg::CMD_PUSH_FRONT: begin
               if (full) begin
                  status_in = deq_pkg::STATUS_PUSH_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = head_dec;
                  head_in  = head_dec;
                  count_in = count_ff + 1'b1;
               end
            end
            deq_pkg::CMD_POP_BACK: begin
               if (empty) status_in = deq_pkg::STATUS_POP_EMPTY;
               else       count_in  = count_ff - 1'b1;
            end
            deq_pkg::CMD_POP_FRONT: begin
               if (empty) begin
                  status_in = deq_pkg::STATUS_POP_EMPTY;
               end else begin
                  head_in  = head_inc;
                  count_in = count_ff - 1'b1;
               end
            end
            deq_pkg::CMD_CLEAR: begin
               head_in  = '0;
               count_in = '0;
            end
            default: begin
               status_in = deq_pkg::STATUS_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         status_ff <= deq_pkg::STATUS_DONE;
      end else begin
         head_ff   <= head_in;
         count_ff  <= count_in;
         status_ff <= status_in;
      end
   end

   deq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (cmd.load),
      .rd_addr_a (head_ff),
      .rd_addr_b (back_addr),
      .rd_data_a (front_q),
      .rd_data_b (back_q)
   );

   assign front_s   = front_q;
   assign back_s    = back_q;
   assign front_ext = 64'(front_s);
   assign back_ext  = 64'(back_s);

   always_comb begin
      rsp_data.ends_valid    = !empty;
      rsp_data.element_count = 7'(count_ff);
      rsp_data.status        = status_ff;
      rsp_data.front_value   = empty ? '0 : front_ext[31:0];
      rsp_data.back_value    = empty ? '0 : back_ext[31:0];
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CW'(CAPACITY)) && (head_ff <= AW'(CAPACITY - 1)))
      else $error("count or head out of range");

   a_reject_keeps: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && (status_in != deq_pkg::STATUS_DONE)) |=>
      ($stable(count_ff) && $stable(head_ff)))
      else $error("rejected command changed the queue");

endmodule

`default_nettype wire
